/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
// JAES_ASSERT is masked while rst is high; JAES_ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JAES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JAES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JAES_ASSERT(label, clk, rst, prop, msg)
`define JAES_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* src/jaes_pkg.sv */
package jaes_pkg;

   typedef enum logic [3:0] {
      PH_OPEN   = 4'd0,
      PH_FIRST  = 4'd1,
      PH_ELEM   = 4'd2,
      PH_STR    = 4'd3,
      PH_CONT   = 4'd4,
      PH_SCALAR = 4'd5,
      PH_AFTER  = 4'd6,
      PH_OK     = 4'd7,
      PH_BAD    = 4'd8
   } phase_type;

   localparam logic [1:0] OUTCOME_SCAN = 2'd0;
   localparam logic [1:0] OUTCOME_OK   = 2'd1;
   localparam logic [1:0] OUTCOME_BAD  = 2'd2;

   localparam logic [7:0] CH_LBRACK    = 8'h5B;
   localparam logic [7:0] CH_RBRACK    = 8'h5D;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   typedef struct packed {
      logic       part_of_element;
      logic       element_begins;
      logic       element_complete;
      logic [1:0] outcome;
   } result_type;

   // space, tab, LF, VT, FF, CR
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // phase after a finished element
   function automatic phase_type after_phase(input logic [7:0] c);
      phase_type ph;
      if (is_ws(c)) begin
         ph = PH_AFTER;
      end else if (c == CH_RBRACK) begin
         ph = PH_OK;
      end else if (c == CH_COMMA) begin
         ph = PH_ELEM;
      end else begin
         ph = PH_BAD;
      end
      return ph;
   endfunction

endpackage

/* src/jaes_if.sv */
interface jaes_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface jaes_rsp_if;
   logic       valid;
   logic       ready;
   logic       part_of_element;
   logic       element_begins;
   logic       element_complete;
   logic [1:0] outcome;

   modport source (output valid, output part_of_element, output element_begins,
                   output element_complete, output outcome, input ready);
   modport sink (input valid, input part_of_element, input element_begins,
                 input element_complete, input outcome, output ready);
endinterface

/* src/json_array_element_splitter.sv */
// JSON array element splitter.
// req_port carries one word per byte of an array text (text_byte, with
// final_byte set on the last byte). rsp_port returns exactly one word per
// accepted byte, in order: part_of_element, element_begins, element_complete
// and outcome (0 scanning, 1 array closed, 2 malformed or ended early).
// Two register stages: the accepted byte lands in an input register, the
// scanner state and flag logic sit between it and the result register.
// An accepted byte waits in the input register until the result register is
// free or drains. Throughput: one byte per cycle while rsp_port.ready is high;
// the scan state (phase, nesting depth, quote and escape flags) follows each byte.
// Stalls: while rsp_port.ready is low the result register holds; the input
// register still takes one more word, then req_port.ready drops until the
// result is taken. No word is lost or repeated.
// Reset (synchronous, active high): both stages empty, scanner back to
// waiting for the opening bracket. The scanner also restarts on its own after
// each final byte. MAX_DEPTH bounds container nesting; deeper is malformed.
`include "assert_macros.svh"

module json_array_element_splitter #(
   parameter int MAX_DEPTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   jaes_req_if.sink    req_port,
   jaes_rsp_if.source  rsp_port
);

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;

   // result stage
   logic                 out_valid_ff;
   jaes_pkg::result_type out_ff, out_in;

   logic advance;
   logic load;

   // input word moves into the result register when that slot is free or drains
   assign advance = in_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !in_valid_ff || advance;
   assign load = req_port.valid && req_port.ready;

   jaes_scan #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .result     (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff  <= req_port.text_byte;
         in_final_ff <= req_port.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_port.valid            = out_valid_ff;
   assign rsp_port.part_of_element  = out_ff.part_of_element;
   assign rsp_port.element_begins   = out_ff.element_begins;
   assign rsp_port.element_complete = out_ff.element_complete;
   assign rsp_port.outcome          = out_ff.outcome;

   // a closed array never flags a byte as element text
   `JAES_ASSERT(a_ok_no_flags, clock, reset, (out_valid_ff && out_ff.outcome == jaes_pkg::OUTCOME_OK) |-> (!out_ff.part_of_element && !out_ff.element_begins), "closed array with element flags")
   // a held input word keeps its byte while the result side is blocked
   `JAES_ASSERT(a_in_hold, clock, reset, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_final_ff)), "input stage lost or changed a waiting word")
   // both stages come out of reset empty
   `JAES_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!out_valid_ff && !in_valid_ff), "pipeline not empty after reset")

endmodule

/* src/jaes_scan.sv */
module jaes_scan #(
   parameter int MAX_DEPTH = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             text_byte,
   input  logic                   final_byte,
   output jaes_pkg::result_type   result
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

   jaes_pkg::phase_type phase_ff, phase_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                quoted_ff, quoted_in;
   logic                escape_ff, escape_in;

   always_comb begin
      phase_in  = phase_ff;
      depth_in  = depth_ff;
      quoted_in = quoted_ff;
      escape_in = escape_ff;
      result    = '0;

      case (phase_ff)
         jaes_pkg::PH_OPEN: begin
            if (text_byte == jaes_pkg::CH_LBRACK) begin
               phase_in = jaes_pkg::PH_FIRST;
            end else if (!jaes_pkg::is_ws(text_byte)) begin
               phase_in = jaes_pkg::PH_BAD;
            end
         end
         jaes_pkg::PH_FIRST, jaes_pkg::PH_ELEM: begin
            if (phase_ff == jaes_pkg::PH_FIRST && text_byte == jaes_pkg::CH_RBRACK) begin
               phase_in = jaes_pkg::PH_OK;
            end else if (!jaes_pkg::is_ws(text_byte)) begin
               if (text_byte == jaes_pkg::CH_QUOTE) begin
                  escape_in = 1'b0;
                  phase_in  = jaes_pkg::PH_STR;
                  result.part_of_element = 1'b1;
                  result.element_begins  = 1'b1;
               end else if (text_byte inside {jaes_pkg::CH_LBRACE, jaes_pkg::CH_LBRACK}) begin
                  depth_in  = DEPTH_ONE;
                  quoted_in = 1'b0;
                  escape_in = 1'b0;
                  phase_in  = jaes_pkg::PH_CONT;
                  result.part_of_element = 1'b1;
                  result.element_begins  = 1'b1;
               end else if (text_byte inside {jaes_pkg::CH_COMMA, jaes_pkg::CH_RBRACK,
                                              jaes_pkg::CH_RBRACE}) begin
                  phase_in = jaes_pkg::PH_BAD;
               end else begin
                  phase_in = jaes_pkg::PH_SCALAR;
                  result.part_of_element = 1'b1;
                  result.element_begins  = 1'b1;
               end
            end
         end
         jaes_pkg::PH_STR: begin
            result.part_of_element = 1'b1;
            if (escape_ff) begin
               escape_in = 1'b0;
            end else if (text_byte == jaes_pkg::CH_BACKSLASH) begin
               escape_in = 1'b1;
            end else if (text_byte == jaes_pkg::CH_QUOTE) begin
               result.element_complete = 1'b1;
               phase_in = jaes_pkg::PH_AFTER;
            end
         end
         jaes_pkg::PH_CONT: begin
            result.part_of_element = 1'b1;
            if (quoted_ff) begin
               if (escape_ff) begin
                  escape_in = 1'b0;
               end else if (text_byte == jaes_pkg::CH_BACKSLASH) begin
                  escape_in = 1'b1;
               end else if (text_byte == jaes_pkg::CH_QUOTE) begin
                  quoted_in = 1'b0;
               end
            end else if (text_byte == jaes_pkg::CH_QUOTE) begin
               quoted_in = 1'b1;
               escape_in = 1'b0;
            end else if (text_byte inside {jaes_pkg::CH_LBRACE, jaes_pkg::CH_LBRACK}) begin
               if (depth_ff >= DEPTH_MAX) begin
                  result.part_of_element = 1'b0;
                  phase_in = jaes_pkg::PH_BAD;
               end else begin
                  depth_in = depth_ff + DEPTH_ONE;
               end
            end else if (text_byte inside {jaes_pkg::CH_RBRACE, jaes_pkg::CH_RBRACK}) begin
               // brackets of either kind count; kinds are not matched
               if (depth_ff <= DEPTH_ONE) begin
                  depth_in = '0;
                  result.element_complete = 1'b1;
                  phase_in = jaes_pkg::PH_AFTER;
               end else begin
                  depth_in = depth_ff - DEPTH_ONE;
               end
            end
         end
         jaes_pkg::PH_SCALAR: begin
            if (jaes_pkg::is_ws(text_byte) ||
                text_byte inside {jaes_pkg::CH_COMMA, jaes_pkg::CH_RBRACK,
                                  jaes_pkg::CH_RBRACE}) begin
               result.element_complete = 1'b1;
               phase_in = jaes_pkg::after_phase(text_byte);
            end else begin
               result.part_of_element  = 1'b1;
               result.element_complete = final_byte;
            end
         end
         jaes_pkg::PH_AFTER: begin
            phase_in = jaes_pkg::after_phase(text_byte);
         end
         jaes_pkg::PH_OK, jaes_pkg::PH_BAD: begin
         end
         default: begin
            phase_in = jaes_pkg::PH_BAD;
         end
      endcase

      if (phase_in == jaes_pkg::PH_OK) begin
         result.outcome = jaes_pkg::OUTCOME_OK;
      end else if (phase_in == jaes_pkg::PH_BAD || final_byte) begin
         result.outcome = jaes_pkg::OUTCOME_BAD;
      end else begin
         result.outcome = jaes_pkg::OUTCOME_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jaes_pkg::PH_OPEN;
         depth_ff  <= '0;
         quoted_ff <= 1'b0;
         escape_ff <= 1'b0;
      end else if (advance) begin
         if (final_byte) begin
            phase_ff  <= jaes_pkg::PH_OPEN;
            depth_ff  <= '0;
            quoted_ff <= 1'b0;
            escape_ff <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            depth_ff  <= depth_in;
            quoted_ff <= quoted_in;
            escape_ff <= escape_in;
         end
      end
   end

endmodule

/* sim/json_split_checker.sv */
// Watches both channels of the splitter, predicts each result word from the
// accepted byte words and compares them in order.
module json_split_checker
   import jaes_pkg::*;
#(
   parameter int NEST_LIMIT = 255
) (
   input  logic clock,
   input  logic reset,
   jaes_req_if  req,
   jaes_rsp_if  rsp,
   output int   mismatches,
   output int   waiting
);

   // scanner state, mirrored
   phase_type   ph;
   int unsigned nest;
   bit          quoted;
   bit          esc_pend;

   result_type  due_q[$];
   result_type  got_word;
   result_type  want_word;
   result_type  pred_word;
   int          errs = 0;
   int          seen = 0;

   task automatic report(input string msg);
      errs++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic void restart();
      ph       = PH_OPEN;
      nest     = 0;
      quoted   = 1'b0;
      esc_pend = 1'b0;
   endfunction

   function automatic bit blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // where the scan goes on the byte that follows an element
   function automatic phase_type past_element(input logic [7:0] c);
      if (blank(c)) begin
         return PH_AFTER;
      end else if (c == CH_RBRACK) begin
         return PH_OK;
      end else if (c == CH_COMMA) begin
         return PH_ELEM;
      end
      return PH_BAD;
   endfunction

   function automatic result_type scan_byte(input logic [7:0] c, input logic fin);
      result_type r;
      bit         starts;
      r      = '0;
      starts = 1'b0;
      case (ph)
         PH_OPEN: begin
            if (c == CH_LBRACK) begin
               ph = PH_FIRST;
            end else if (!blank(c)) begin
               ph = PH_BAD;
            end
         end
         PH_FIRST, PH_ELEM: begin
            if (ph == PH_FIRST && c == CH_RBRACK) begin
               ph = PH_OK;
            end else if (!blank(c)) begin
               case (c)
                  CH_QUOTE: begin
                     esc_pend = 1'b0;
                     ph       = PH_STR;
                     starts   = 1'b1;
                  end
                  CH_LBRACE, CH_LBRACK: begin
                     nest     = 1;
                     quoted   = 1'b0;
                     esc_pend = 1'b0;
                     ph       = PH_CONT;
                     starts   = 1'b1;
                  end
                  CH_COMMA, CH_RBRACK, CH_RBRACE: begin
                     ph = PH_BAD;
                  end
                  default: begin
                     ph     = PH_SCALAR;
                     starts = 1'b1;
                  end
               endcase
            end
            r.part_of_element = starts;
            r.element_begins  = starts;
         end
         PH_STR: begin
            r.part_of_element = 1'b1;
            if (esc_pend) begin
               esc_pend = 1'b0;
            end else if (c == CH_BACKSLASH) begin
               esc_pend = 1'b1;
            end else if (c == CH_QUOTE) begin
               r.element_complete = 1'b1;
               ph = PH_AFTER;
            end
         end
         PH_CONT: begin
            r.part_of_element = 1'b1;
            if (quoted) begin
               if (esc_pend) begin
                  esc_pend = 1'b0;
               end else if (c == CH_BACKSLASH) begin
                  esc_pend = 1'b1;
               end else if (c == CH_QUOTE) begin
                  quoted = 1'b0;
               end
            end else if (c == CH_QUOTE) begin
               quoted   = 1'b1;
               esc_pend = 1'b0;
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
               if (nest >= NEST_LIMIT) begin
                  r.part_of_element = 1'b0;
                  ph = PH_BAD;
               end else begin
                  nest++;
               end
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
               if (nest > 0) begin
                  nest--;
               end
               if (nest == 0) begin
                  r.element_complete = 1'b1;
                  ph = PH_AFTER;
               end
            end
         end
         PH_SCALAR: begin
            if (c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE || blank(c)) begin
               r.element_complete = 1'b1;
               ph = past_element(c);
            end else begin
               r.part_of_element  = 1'b1;
               r.element_complete = fin;
            end
         end
         PH_AFTER: begin
            ph = past_element(c);
         end
         PH_OK, PH_BAD: begin
         end
         default: begin
            ph = PH_BAD;
         end
      endcase
      if (ph == PH_OK) begin
         r.outcome = OUTCOME_OK;
      end else if (ph == PH_BAD) begin
         r.outcome = OUTCOME_BAD;
      end else begin
         r.outcome = OUTCOME_SCAN;
      end
      if (fin && r.outcome == OUTCOME_SCAN) begin
         r.outcome = OUTCOME_BAD;
      end
      if (fin) begin
         restart();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart();
         due_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got_word = {rsp.part_of_element, rsp.element_begins,
                        rsp.element_complete, rsp.outcome};
            if (due_q.size() == 0) begin
               report($sformatf("word %0d arrived with nothing pending", seen));
            end else begin
               want_word = due_q.pop_front();
               if (got_word.part_of_element !== want_word.part_of_element) begin
                  report($sformatf("word %0d part_of_element %b, want %b", seen,
                                   got_word.part_of_element, want_word.part_of_element));
               end
               if (got_word.element_begins !== want_word.element_begins) begin
                  report($sformatf("word %0d element_begins %b, want %b", seen,
                                   got_word.element_begins, want_word.element_begins));
               end
               if (got_word.element_complete !== want_word.element_complete) begin
                  report($sformatf("word %0d element_complete %b, want %b", seen,
                                   got_word.element_complete, want_word.element_complete));
               end
               if (got_word.outcome !== want_word.outcome) begin
                  report($sformatf("word %0d outcome %0d, want %0d", seen,
                                   got_word.outcome, want_word.outcome));
               end
            end
            seen++;
         end
         if (req.valid && req.ready) begin
            pred_word = scan_byte(req.text_byte, req.final_byte);
            due_q.insert(due_q.size(), pred_word);
         end
      end
      waiting    <= due_q.size();
      mismatches <= errs;
   end

endmodule

/* sim/tb_top.sv */
// Top of the splitter bench: clock, reset, byte-word stimulus, result-side
// backpressure, watchdog and verdict. All prediction and comparison lives in
// json_split_checker.
module tb_top;
   import jaes_pkg::*;

   localparam int NEST_LIMIT  = 255;
   localparam int ITEM_TARGET = 1150;  // byte words to send before stopping
   localparam int HOLD_CYCLES = 64;    // long result-side hold-off
   localparam int QUIET_LIMIT = 2000;  // cycles with no word moving = hang

   logic clock;
   logic reset = 1'b1;

   jaes_req_if req_bus ();
   jaes_rsp_if rsp_bus ();

   int  mismatches;
   int  waiting;

   // shared between stimulus and receiver
   bit  calm          = 1'b0;  // no idling on either side while set
   bit  stall_request = 1'b0;  // receiver does one long hold-off when set
   int  words_sent    = 0;

   logic [7:0] text_q[$];      // bytes of the text being built

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   json_array_element_splitter #(
      .MAX_DEPTH (NEST_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   json_split_checker #(
      .NEST_LIMIT (NEST_LIMIT)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .mismatches (mismatches),
      .waiting    (waiting)
   );

   // ---------------------------------------------------------------------
   // Text builders. Each appends to text_q.
   // ---------------------------------------------------------------------

   function automatic void add_byte(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endfunction

   // 0..most whitespace bytes, any of the six kinds
   function automatic void put_ws(input int most);
      int k;
      repeat ($urandom_range(most)) begin
         k = $urandom_range(5);
         add_byte(k == 0 ? CH_SPACE : 8'(CH_TAB + k - 1));
      end
   endfunction

   // quoted string; escapes may carry any byte, including a quote
   function automatic void put_string();
      logic [7:0] c;
      add_byte(CH_QUOTE);
      repeat ($urandom_range(6)) begin
         if ($urandom_range(9) == 0) begin
            add_byte(CH_BACKSLASH);
            add_byte(8'($urandom_range(255)));
         end else begin
            do c = 8'($urandom_range(255));
            while (c == CH_QUOTE || c == CH_BACKSLASH);
            add_byte(c);
         end
      end
      add_byte(CH_QUOTE);
   endfunction

   // bare scalar: no whitespace, brackets, braces, commas or quotes
   function automatic void put_scalar();
      logic [7:0] c;
      repeat ($urandom_range(1, 5)) begin
         do c = 8'($urandom_range(255, 8'h21));
         while (c == CH_COMMA || c == CH_LBRACK || c == CH_RBRACK ||
                c == CH_LBRACE || c == CH_RBRACE || c == CH_QUOTE);
         add_byte(c);
      end
   endfunction

   // string, scalar or container; containers use random bracket kinds and
   // open and close kinds need not match
   function automatic void put_element(input int level);
      int parts;
      case ($urandom_range(2))
         0: put_string();
         1: put_scalar();
         default: begin
            if (level < 3) begin
               add_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
               parts = $urandom_range(3);
               for (int k = 0; k < parts; k++) begin
                  if (k > 0) begin
                     add_byte(CH_COMMA);
                  end
                  put_ws(1);
                  put_element(level + 1);
                  put_ws(1);
               end
               add_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
            end else begin
               put_scalar();
            end
         end
      endcase
   endfunction

   // well-formed array, optional leading and trailing whitespace
   function automatic void put_array();
      int n;
      if ($urandom_range(3) == 0) begin
         put_ws(2);
      end
      add_byte(CH_LBRACK);
      put_ws(1);
      n = $urandom_range(4);
      for (int k = 0; k < n; k++) begin
         if (k > 0) begin
            add_byte(CH_COMMA);
         end
         put_ws(1);
         put_element(1);
         put_ws(1);
      end
      add_byte(CH_RBRACK);
      if ($urandom_range(3) == 0) begin
         put_ws(2);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // One byte word. Valid only drops when a gap is actually taken, so a
   // back-to-back word never sees valid lowered and raised in one step.
   task automatic send_word(input logic [7:0] b, input logic fin);
      if (!calm && $urandom_range(99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= b;
      req_bus.final_byte <= fin;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   // sends text_q with the final flag on its last byte, then empties it
   task automatic send_text();
      foreach (text_q[i]) begin
         send_word(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: ~20% idle, none while calm, one long hold-off on request
   // so the two internal stages fill and the input stalls.
   // ---------------------------------------------------------------------
   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_request = 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 20);
         end
      end
   end

   // Hang detector: any cycle with a word moving on either side clears it.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int         pick;
      int         keep;
      int         pos;
      logic [7:0] b;
      bit         paused;
      bit         held;
      bit         deep_done;

      paused    = 1'b0;
      held      = 1'b0;
      deep_done = 1'b0;
      req_bus.valid      <= 1'b0;
      req_bus.text_byte  <= 8'h00;
      req_bus.final_byte <= 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed texts ---
      // empty array
      put_str("[]");
      send_text();
      // leading blank, escaped quote in a string, quoted ']' inside a
      // container that opens with '{' and closes with ']'
      put_str(" [\"\\\"\",{\"]\"]]");
      send_text();
      // '}' ends a scalar but is malformed
      put_str("[7}");
      send_text();
      // text ends on a scalar byte
      put_str("[5");
      send_text();
      // bad first byte (zero), then a byte after the decided outcome
      add_byte(8'h00);
      add_byte(8'hFF);
      send_text();
      // text ends with an escape pending inside a string
      put_str("[\"\\");
      send_text();

      // --- random texts ---
      while (words_sent < ITEM_TARGET) begin
         // long stretch with no idling on either side
         calm = (words_sent >= 200 && words_sent < 380);

         // drain: hold the input until every pending result is back
         if (!paused && words_sent >= 450) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (waiting != 0);
         end

         // result side holds off while bytes keep being offered
         if (!held && words_sent >= 650) begin
            held = 1'b1;
            stall_request = 1'b1;
         end

         if (!deep_done && words_sent >= 800) begin
            // nest up to the depth limit, then one opening more: the last
            // '[' overflows; the closing ']' after it is ignored
            deep_done = 1'b1;
            repeat (NEST_LIMIT + 2) add_byte(CH_LBRACK);
            add_byte(CH_RBRACK);
         end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               put_array();
            end else if (pick < 75) begin
               // cut short: early end somewhere inside
               put_array();
               keep = $urandom_range(1, text_q.size());
               text_q = text_q[0:keep-1];
            end else if (pick < 85) begin
               // one byte replaced by a structural one or noise
               put_array();
               pos = $urandom_range(text_q.size() - 1);
               case ($urandom_range(5))
                  0: b = CH_COMMA;
                  1: b = CH_RBRACK;
                  2: b = CH_RBRACE;
                  3: b = CH_QUOTE;
                  4: b = CH_LBRACE;
                  default: b = 8'($urandom_range(255));
               endcase
               text_q[pos] = b;
            end else if (pick < 92) begin
               // pure noise
               repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
            end else begin
               // closed array followed by junk that must be ignored
               put_array();
               repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
            end
         end
         send_text();
      end

      // --- wind down: let the pipeline empty, then a few cycles more ---
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (waiting != 0);
      repeat (4) @(posedge clock);

      if (mismatches == 0 && waiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* json_array_element_splitter.f */
+incdir+src
src/jaes_pkg.sv
src/jaes_if.sv
src/jaes_scan.sv
src/json_array_element_splitter.sv
sim/json_split_checker.sv
sim/tb_top.sv
